FILE: sv/deeoc_pkg.sv
package deeoc_pkg;

   // Fixed field widths.
   localparam int DIST_W     = 12;
   localparam int STABLE_W   = 4;
   localparam int OCC_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   // Register reset values.
   localparam logic [DIST_W-1:0]   THRESH_RESET = 12'd150;
   localparam logic [STABLE_W-1:0] STABLE_RESET = 4'd2;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_STABLE    = 1'b1
   } csr_index_type;

   // One input item: a pair of distance readings.
   typedef struct packed {
      logic [DIST_W-1:0] entrance_distance;
      logic [DIST_W-1:0] exit_distance;
   } req_payload_type;

   // One result item.
   typedef struct packed {
      logic [OCC_W-1:0] occupancy;
      logic             entrance_present;
      logic             exit_present;
   } rsp_payload_type;

   // Status that a sensor debouncer hands to the rest of the block.
   typedef struct packed {
      logic present;
      logic fell;
   } sensor_status_type;

endpackage

FILE: sv/debounced_entry_exit_occupancy_counter.sv
// Channel | Ports                          | Direction | Payload
// req     | req_valid, req_ready           | in        | req_payload_type
// rsp     | rsp_valid, rsp_ready           | out       | rsp_payload_type
// csr     | csr_we, csr_index, csr_wdata   | in        | threshold, stable count
//
// One item per cycle while the result is not stalled. An item is held in the input register; the
// sensor and count update run between it and the result register.
// An accepted item passes through the input register, then the result register.
// Reset is synchronous; it clears the flags, runs, count and valid bits and restores the configuration registers.
// A stalled result holds the input register; req_ready drops only when both are full.
module debounced_entry_exit_occupancy_counter
   import deeoc_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DIST_W-1:0]   threshold_ff;
   logic [STABLE_W-1:0] stable_ff;
   logic                in_valid_ff;
   req_payload_type     in_data_ff;
   logic                out_valid_ff;
   rsp_payload_type     out_data_ff;
   rsp_payload_type     out_data_in;
   logic                advance;
   sensor_status_type   entrance_status;
   sensor_status_type   exit_status;
   logic [OCC_W-1:0]    occupancy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         stable_ff    <= STABLE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= csr_wdata[DIST_W-1:0];
            CSR_STABLE:    stable_ff    <= csr_wdata[STABLE_W-1:0];
            default:       ;
         endcase
      end
   end

   // The held item moves on when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   deeoc_sensor u_entrance (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .distance       (in_data_ff.entrance_distance),
      .threshold      (threshold_ff),
      .stable_samples (stable_ff),
      .status         (entrance_status)
   );

   deeoc_sensor u_exit (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .distance       (in_data_ff.exit_distance),
      .threshold      (threshold_ff),
      .stable_samples (stable_ff),
      .status         (exit_status)
   );

   deeoc_count #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .inc       (entrance_status.fell),
      .dec       (exit_status.fell),
      .occupancy (occupancy)
   );

   // Result register.
   always_comb begin
      out_data_in.occupancy        = occupancy;
      out_data_in.entrance_present = entrance_status.present;
      out_data_in.exit_present     = exit_status.present;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // A full input stage behind a stalled result blocks new items.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("item accepted while both stages are stalled");

   // A taken result with nothing behind it leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ready && !advance) |=> !out_valid_ff)
      else $error("result repeated after it was taken");

   // Every processed item shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed item lost");

endmodule

FILE: sv/deeoc_sensor.sv
module deeoc_sensor
   import deeoc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [DIST_W-1:0]   distance,
   input  logic [DIST_W-1:0]   threshold,
   input  logic [STABLE_W-1:0] stable_samples,
   output sensor_status_type   status
);

   logic                flag_ff;
   logic                flag_in;
   logic [STABLE_W-1:0] run_ff;
   logic [STABLE_W-1:0] run_in;
   logic                raw;
   logic                fell;
   logic [STABLE_W-1:0] run_inc;

   // A reading below the threshold means an object is present.
   assign raw     = (distance < threshold);
   assign run_inc = run_ff + 1'b1;

   // The run counts disagreeing samples; the flag flips once the run is long enough.
   always_comb begin
      flag_in = flag_ff;
      run_in  = run_ff;
      fell    = 1'b0;
      if (raw == flag_ff) begin
         run_in = '0;
      end else if (run_inc >= stable_samples) begin
         flag_in = raw;
         run_in  = '0;
         fell    = !raw;
      end else begin
         run_in = run_inc;
      end
   end

   assign status = {flag_in, fell};

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
         run_ff  <= '0;
      end else if (advance) begin
         flag_ff <= flag_in;
         run_ff  <= run_in;
      end
   end

   // The debounce state moves only when an item is processed.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(flag_ff) && $stable(run_ff)))
      else $error("sensor state changed without an item");

   // A falling edge is reported only from a set flag.
   assert property (@(posedge clock) disable iff (reset)
      status.fell |-> (flag_ff && !status.present))
      else $error("falling edge reported from a clear flag");

endmodule

FILE: sv/deeoc_count.sv
module deeoc_count
   import deeoc_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             inc,
   input  logic             dec,
   output logic [OCC_W-1:0] occupancy
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_mid;
   logic [COUNT_BITS-1:0] count_in;

   // Entrance first, saturating at the top; then exit, floored at zero.
   always_comb begin
      count_mid = count_ff;
      if (inc && (count_ff != '1)) begin
         count_mid = count_ff + 1'b1;
      end
      count_in = count_mid;
      if (dec && (count_mid != '0)) begin
         count_in = count_mid - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

   // The reported occupancy is the updated count, cut to its low bits or zero-extended to OCC_W.
   generate
      if (COUNT_BITS >= OCC_W) begin : g_trunc
         assign occupancy = count_in[OCC_W-1:0];
      end else begin : g_ext
         assign occupancy = {{(OCC_W-COUNT_BITS){1'b0}}, count_in};
      end
   endgenerate

endmodule
